### sv/sda_pkg.sv
`timescale 1ns / 1ps

package sda_pkg;

  // field widths
  localparam int VAL_W  = 32;
  localparam int CHAR_W = 8;
  localparam int FRAC_W = 4;
  localparam int DIG_N  = 10;
  localparam int BCD_W  = 4 * DIG_N;
  localparam int CNT_W  = 5;

  // largest usable fraction digit count
  localparam logic [FRAC_W-1:0] FRAC_MAX = 4'd9;

  // character codes
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2E;

  typedef logic [3:0] digit_t;

  // per-request facts handed from the front end to the character sequencer
  typedef struct packed {
    logic              neg;
    logic              zero;
    logic [FRAC_W-1:0] frac;
  } job_t;

endpackage

### sv/sda_dabble.sv
`timescale 1ns / 1ps

// bit-serial binary to bcd, one input bit per cycle (shift and add-3)
module sda_dabble (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       load,
  input  logic [sda_pkg::VAL_W-1:0]  mag,
  output logic                       done,
  output logic [sda_pkg::BCD_W-1:0]  bcd
);

  logic [sda_pkg::VAL_W-1:0] bin_r;
  logic [sda_pkg::BCD_W-1:0] bcd_r;
  logic [sda_pkg::CNT_W-1:0] cnt_r;
  logic                      run_r;
  logic                      done_r;
  logic [sda_pkg::BCD_W-1:0] adj;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < sda_pkg::DIG_N; i++) begin
      if (bcd_r[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_r[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd_r[4*i +: 4];
      end
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (load) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == {sda_pkg::CNT_W{1'b1}}) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // shift path
  always_ff @(posedge clk) begin
    if (load) begin
      bin_r <= mag;
      bcd_r <= '0;
    end else if (run_r) begin
      bin_r <= {bin_r[sda_pkg::VAL_W-2:0], 1'b0};
      bcd_r <= {adj[sda_pkg::BCD_W-2:0], bin_r[sda_pkg::VAL_W-1]};
    end
  end

  assign done = done_r;
  assign bcd  = bcd_r;

endmodule

### sv/sda_emit.sv
`timescale 1ns / 1ps

// character sequencer: sign, leading "0.", digits with the point inserted
module sda_emit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        go,
  input  logic [sda_pkg::BCD_W-1:0]   bcd,
  input  sda_pkg::job_t               job,
  output logic                        strobe,
  output logic [sda_pkg::CHAR_W-1:0]  char_code,
  output logic                        last
);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_SIGN, S_LEAD0, S_LEADPT, S_DIGIT, S_POINT
  } state_t;

  state_t                       state_r, state_nxt;
  logic [3:0]                   pos_r, pos_nxt;
  logic                         prefix_r, prefix_nxt;
  logic                         strobe_r, strobe_nxt;
  logic [sda_pkg::CHAR_W-1:0]   char_r, char_nxt;
  logic                         last_r, last_nxt;
  sda_pkg::digit_t              dig_r [sda_pkg::DIG_N];
  logic [3:0]                   nd;
  logic                         below;

  // capture converted digits
  always_ff @(posedge clk) begin
    if (go) begin
      for (int i = 0; i < sda_pkg::DIG_N; i++) begin
        dig_r[i] <= bcd[4*i +: 4];
      end
    end
  end

  // count of significant digits
  always_comb begin
    nd = '0;
    for (int i = 0; i < sda_pkg::DIG_N; i++) begin
      if (dig_r[i] != 4'd0) begin
        nd = 4'(i + 1);
      end
    end
  end

  assign below = (nd <= job.frac);

  // next state and next output
  always_comb begin
    state_nxt  = state_r;
    pos_nxt    = pos_r;
    prefix_nxt = prefix_r;
    strobe_nxt = 1'b0;
    char_nxt   = char_r;
    last_nxt   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (go) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        prefix_nxt = below;
        if (job.zero) begin
          pos_nxt = '0;
        end else if (below) begin
          pos_nxt = job.frac - 4'd1;
        end else begin
          pos_nxt = nd - 4'd1;
        end
        if (job.neg) begin
          state_nxt = S_SIGN;
        end else if (below) begin
          state_nxt = S_LEAD0;
        end else begin
          state_nxt = S_DIGIT;
        end
      end
      S_SIGN: begin
        strobe_nxt = 1'b1;
        char_nxt   = sda_pkg::CHAR_MINUS;
        state_nxt  = prefix_r ? S_LEAD0 : S_DIGIT;
      end
      S_LEAD0: begin
        strobe_nxt = 1'b1;
        char_nxt   = sda_pkg::CHAR_ZERO;
        state_nxt  = S_LEADPT;
      end
      S_LEADPT: begin
        strobe_nxt = 1'b1;
        char_nxt   = sda_pkg::CHAR_POINT;
        state_nxt  = S_DIGIT;
      end
      S_DIGIT: begin
        strobe_nxt = 1'b1;
        char_nxt   = sda_pkg::CHAR_ZERO + {4'd0, dig_r[pos_r]};
        if (!prefix_r && job.frac != '0 && pos_r == job.frac) begin
          state_nxt = S_POINT;
        end else if (pos_r == '0) begin
          last_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          pos_nxt = pos_r - 4'd1;
        end
      end
      S_POINT: begin
        strobe_nxt = 1'b1;
        char_nxt   = sda_pkg::CHAR_POINT;
        pos_nxt    = pos_r - 4'd1;
        state_nxt  = S_DIGIT;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      strobe_r <= 1'b0;
      last_r   <= 1'b0;
      pos_r    <= '0;
      prefix_r <= 1'b0;
      char_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
      last_r   <= last_nxt;
      pos_r    <= pos_nxt;
      prefix_r <= prefix_nxt;
      char_r   <= char_nxt;
    end
  end

  assign strobe    = strobe_r;
  assign char_code = char_r;
  assign last      = last_r;

endmodule

### sv/scaled_decimal_to_ascii_unit.sv
`timescale 1ns / 1ps

// Signed 32-bit value to ASCII decimal text, with a fixed decimal point.
// Request: pulse start with in_value while busy is low; the request is taken
// at that edge and busy stays high until the last character has been shown.
// Results: one character per out_strobe cycle on out_char_code, out_last
// high on the final one. Characters of one request come on back-to-back
// cycles. The receiver cannot stall; every strobe cycle is a taken result.
// Config: cfg_fraction_digits is written when cfg_valid is high (cfg_ready is
// always high); write it only while busy is low. Values above 9 act as 9.
// Reset clears the fraction count to 0, drops busy and all strobes.
// Sequence: bit-serial binary to BCD (one input bit a cycle), then the
// digits are captured and the leading one located, then the output
// register, then 1 to 12 characters, one a cycle.
// A request occupies the block until its last character has been shown.
module scaled_decimal_to_ascii_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [sda_pkg::VAL_W-1:0] in_value,
  output logic                        out_strobe,
  output logic [sda_pkg::CHAR_W-1:0]  out_char_code,
  output logic                        out_last,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [sda_pkg::FRAC_W-1:0]  cfg_fraction_digits
);

  logic [sda_pkg::FRAC_W-1:0] frac_cfg_r;
  logic                       busy_r;
  sda_pkg::job_t              job_r;
  logic                       accept;
  logic [sda_pkg::VAL_W-1:0]  mag;
  logic                       conv_done;
  logic [sda_pkg::BCD_W-1:0]  conv_bcd;

  assign accept    = start && !busy_r;
  assign cfg_ready = 1'b1;

  // magnitude, most negative value wraps to its unsigned magnitude
  assign mag = in_value[sda_pkg::VAL_W-1] ? (~in_value + 1'b1) : in_value;

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frac_cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      frac_cfg_r <= cfg_fraction_digits;
    end
  end

  // busy flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (accept) begin
      busy_r <= 1'b1;
    end else if (out_strobe && out_last) begin
      busy_r <= 1'b0;
    end
  end

  // request facts held for the sequencer
  always_ff @(posedge clk) begin
    if (accept) begin
      job_r.neg  <= in_value[sda_pkg::VAL_W-1];
      job_r.zero <= (in_value == '0);
      job_r.frac <= (frac_cfg_r > sda_pkg::FRAC_MAX) ? sda_pkg::FRAC_MAX : frac_cfg_r;
    end
  end

  sda_dabble u_dabble (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (accept),
    .mag   (mag),
    .done  (conv_done),
    .bcd   (conv_bcd)
  );

  sda_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (conv_done),
    .bcd       (conv_bcd),
    .job       (job_r),
    .strobe    (out_strobe),
    .char_code (out_char_code),
    .last      (out_last)
  );

  assign busy = busy_r;

  // characters only appear while a request is open
  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy_r)
    else $error("character outside a request");

  // characters of one request come without gaps
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last |=> out_strobe)
    else $error("gap inside a character run");

  // the last character closes the request
  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_last |=> !busy_r && !out_strobe)
    else $error("request not closed after last character");

  // conversion finishes only while a request is open
  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    conv_done |-> busy_r && !out_strobe)
    else $error("conversion done outside a request");

endmodule
